// File: hdl/kmrc_pkg.sv
// ----------------------------------------------------------------------------
// kmrc_pkg
// Shared types, constants and functions for the k-mer reverse complement
// deduplicating set: table geometry, entry layout, status codes, hashing.
// ----------------------------------------------------------------------------
package kmrc_pkg;

  localparam int unsigned CAPACITY  = 4096;
  localparam int unsigned ADDR_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned KMER_W    = 64;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned UCOUNT_W  = 13;
  localparam int unsigned EPOCH_W   = 4;
  localparam int unsigned SYMS      = KMER_W / 2;

  localparam logic [LEN_W-1:0]   LEN_RESET = LEN_W'(31);
  localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(SYMS);
  localparam logic [ADDR_W-1:0]  ADDR_LAST = ADDR_W'(CAPACITY - 1);
  localparam logic [EPOCH_W-1:0] EPOCH_CLR = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LST = '1;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW  = 2'd0,
    ST_SKIP = 2'd1,
    ST_DUP  = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [KMER_W-1:0]  kmer;
  } entry_t;

  // invert, reverse the 2-bit symbols, right-align to k symbols
  function automatic logic [KMER_W-1:0] revcomp(input logic [KMER_W-1:0] w,
                                                input logic [LEN_W-1:0]  len);
    logic [KMER_W-1:0] inv;
    logic [KMER_W-1:0] rev;
    logic [LEN_W-1:0]  k;
    logic [LEN_W+1:0]  shamt;
    inv = ~w;
    for (int i = 0; i < SYMS; i++) begin
      rev[2*i +: 2] = inv[2*(SYMS-1-i) +: 2];
    end
    k = len;
    if (k == '0) k = LEN_W'(1);
    if (k > LEN_MAX) k = LEN_MAX;
    shamt = (LEN_W+2)'(KMER_W) - {1'b0, k, 1'b0};
    return rev >> shamt;
  endfunction

  // xor fold onto the table index, reduced below the capacity
  function automatic logic [ADDR_W-1:0] slot_hash(input logic [KMER_W-1:0] v);
    logic [ADDR_W-1:0] h;
    h = '0;
    for (int i = 0; i < KMER_W; i++) begin
      h[i % ADDR_W] = h[i % ADDR_W] ^ v[i];
    end
    if ({1'b0, h} >= (ADDR_W+1)'(CAPACITY)) h = h - ADDR_W'(CAPACITY);
    return h;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_next(input logic [ADDR_W-1:0] a);
    return (a == ADDR_LAST) ? '0 : a + ADDR_W'(1);
  endfunction

endpackage

// File: hdl/kmer_revcomp_dedup_set.sv
// ----------------------------------------------------------------------------
// kmer_revcomp_dedup_set
// Deduplicating k-mer set that skips k-mers whose reverse complement is held.
// Open-addressed hash table in one memory, linear probing, epoch-tagged slots.
// ----------------------------------------------------------------------------
//  channel  signals                                         dir
//  in       in_valid_i in_ready_o kmer_i last_item_i        in
//  out      out_valid_o out_ready_i status_o kmer_out_o     out
//           complement_out_o unique_count_o last_out_o
//  cfg      cfg_valid_i cfg_ready_o cfg_data_i              in
//
//  an item passes S_HASH, S_PROBE, S_DONE; in S_PROBE table slots are probed for the
//  complement and the k-mer, one probe a cycle on the table's read port.
//  after reset and after every fifteenth last item a clearing pass over
//  all CAPACITY slots runs with in_ready_o low; cfg transfers are always taken.
//  a result waiting in the output register does not block the next transfer.
// ----------------------------------------------------------------------------
module kmer_revcomp_dedup_set (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [kmrc_pkg::LEN_W-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [kmrc_pkg::KMER_W-1:0]          kmer_i,
  input  logic                                 last_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [kmrc_pkg::STATUS_W-1:0]        status_o,
  output logic [kmrc_pkg::KMER_W-1:0]          kmer_out_o,
  output logic [kmrc_pkg::KMER_W-1:0]          complement_out_o,
  output logic [kmrc_pkg::UCOUNT_W-1:0]        unique_count_o,
  output logic                                 last_out_o
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_PROBE = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [kmrc_pkg::LEN_W-1:0]   len_q;
  logic [kmrc_pkg::EPOCH_W-1:0] epoch_q, epoch_d;
  logic [kmrc_pkg::CNT_W-1:0]   count_q, count_d;
  logic [kmrc_pkg::ADDR_W-1:0]  addr_q, addr_d;
  logic [kmrc_pkg::ADDR_W-1:0]  probe_q, probe_d;
  logic                         phase_q, phase_d;
  logic [kmrc_pkg::ADDR_W-1:0]  clr_q, clr_d;
  logic                         out_valid_q, out_valid_d;

  logic [kmrc_pkg::KMER_W-1:0]  kmer_q;
  logic [kmrc_pkg::KMER_W-1:0]  comp_q;
  logic                         last_q;
  kmrc_pkg::status_e            res_q, res_d;

  logic [kmrc_pkg::STATUS_W-1:0] ostatus_q;
  logic [kmrc_pkg::KMER_W-1:0]   okmer_q;
  logic [kmrc_pkg::KMER_W-1:0]   ocomp_q;
  logic [kmrc_pkg::UCOUNT_W-1:0] ocount_q;
  logic                          olast_q;

  kmrc_pkg::entry_t             mem_q [kmrc_pkg::CAPACITY];
  kmrc_pkg::entry_t             rd_q;
  kmrc_pkg::entry_t             wr_data;
  logic                         wr_en;
  logic [kmrc_pkg::ADDR_W-1:0]  wr_addr;

  logic [kmrc_pkg::KMER_W-1:0]  key;
  logic                         hit, empty, exhausted;
  logic                         in_xfer, out_free, load_out;
  logic [kmrc_pkg::CNT_W+kmrc_pkg::UCOUNT_W-1:0] count_ext;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign load_out    = (state_q == S_DONE) && out_free;

  assign key       = phase_q ? kmer_q : comp_q;
  assign hit       = (rd_q.epoch == epoch_q) && (rd_q.kmer == key);
  assign empty     = (rd_q.epoch != epoch_q);
  assign exhausted = (probe_q == kmrc_pkg::ADDR_LAST);
  assign count_ext = {{kmrc_pkg::UCOUNT_W{1'b0}}, count_q};

  always_comb begin
    state_d     = state_q;
    epoch_d     = epoch_q;
    count_d     = count_q;
    addr_d      = addr_q;
    probe_d     = probe_q;
    phase_d     = phase_q;
    clr_d       = clr_q;
    res_d       = res_q;
    wr_en       = 1'b0;
    wr_addr     = addr_q;
    wr_data     = '{epoch: epoch_q, kmer: kmer_q};
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '{epoch: kmrc_pkg::EPOCH_CLR, kmer: '0};
        clr_d   = kmrc_pkg::slot_next(clr_q);
        if (clr_q == kmrc_pkg::ADDR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        addr_d  = kmrc_pkg::slot_hash(comp_q);
        probe_d = '0;
        phase_d = 1'b0;
        state_d = S_PROBE;
      end
      S_PROBE: begin
        if (!phase_q) begin
          if (hit) begin
            res_d   = kmrc_pkg::ST_SKIP;
            state_d = S_DONE;
          end else if (empty || exhausted) begin
            phase_d = 1'b1;
            addr_d  = kmrc_pkg::slot_hash(kmer_q);
            probe_d = '0;
          end else begin
            addr_d  = kmrc_pkg::slot_next(addr_q);
            probe_d = probe_q + kmrc_pkg::ADDR_W'(1);
          end
        end else begin
          if (hit) begin
            res_d   = kmrc_pkg::ST_DUP;
            state_d = S_DONE;
          end else if (empty) begin
            wr_en   = 1'b1;
            count_d = count_q + kmrc_pkg::CNT_W'(1);
            res_d   = kmrc_pkg::ST_NEW;
            state_d = S_DONE;
          end else if (exhausted) begin
            res_d   = kmrc_pkg::ST_FULL;
            state_d = S_DONE;
          end else begin
            addr_d  = kmrc_pkg::slot_next(addr_q);
            probe_d = probe_q + kmrc_pkg::ADDR_W'(1);
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (last_q) begin
            count_d = '0;
            if (epoch_q == kmrc_pkg::EPOCH_LST) begin
              epoch_d = kmrc_pkg::EPOCH_FST;
              clr_d   = '0;
              state_d = S_CLEAR;
            end else begin
              epoch_d = epoch_q + kmrc_pkg::EPOCH_W'(1);
            end
          end
        end
      end
      default: begin
        state_d = S_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      len_q       <= kmrc_pkg::LEN_RESET;
      epoch_q     <= kmrc_pkg::EPOCH_FST;
      count_q     <= '0;
      addr_q      <= '0;
      probe_q     <= '0;
      phase_q     <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      res_q       <= kmrc_pkg::ST_NEW;
    end else begin
      state_q     <= state_d;
      epoch_q     <= epoch_d;
      count_q     <= count_d;
      addr_q      <= addr_d;
      probe_q     <= probe_d;
      phase_q     <= phase_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
      if (cfg_valid_i && cfg_ready_o) begin
        len_q <= cfg_data_i;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kmer_q <= kmer_i;
      last_q <= last_item_i;
      comp_q <= kmrc_pkg::revcomp(kmer_i, len_q);
    end
    if (load_out) begin
      ostatus_q <= res_q;
      okmer_q   <= kmer_q;
      ocomp_q   <= comp_q;
      ocount_q  <= count_ext[kmrc_pkg::UCOUNT_W-1:0];
      olast_q   <= last_q;
    end
  end

  // slot table
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[addr_d];
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = ostatus_q;
  assign kmer_out_o       = okmer_q;
  assign complement_out_o = ocomp_q;
  assign unique_count_o   = ocount_q;
  assign last_out_o       = olast_q;

endmodule

// File: tb/kmrc_checker.sv
// ----------------------------------------------------------------------------
// kmrc_checker
// Watches the cfg, input and output channels of the k-mer reverse complement
// set. Keeps its own copy of the k-mer length and of the stored set, predicts
// status, complement and count for every input transfer and compares each
// output transfer with the oldest prediction. Reports failures by count.
// ----------------------------------------------------------------------------
module kmrc_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [kmrc_pkg::LEN_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [kmrc_pkg::KMER_W-1:0]   kmer_i,
  input  logic                          last_item_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [kmrc_pkg::STATUS_W-1:0] status_i,
  input  logic [kmrc_pkg::KMER_W-1:0]   kmer_out_i,
  input  logic [kmrc_pkg::KMER_W-1:0]   complement_out_i,
  input  logic [kmrc_pkg::UCOUNT_W-1:0] unique_count_i,
  input  logic                          last_out_i,
  output int unsigned                   pending_o,
  output int unsigned                   fail_count_o
);

  typedef struct packed {
    kmrc_pkg::status_e             status;
    logic [kmrc_pkg::KMER_W-1:0]   kmer;
    logic [kmrc_pkg::KMER_W-1:0]   mate;
    logic [kmrc_pkg::UCOUNT_W-1:0] ucount;
    logic                          last;
  } kmer_result_t;

  logic [kmrc_pkg::KMER_W-1:0] held_kmers [kmrc_pkg::CAPACITY];
  int unsigned                 held_count;
  logic [kmrc_pkg::LEN_W-1:0]  kmer_len;
  kmer_result_t                due_results [$];

  // reverse complement base by base, right-aligned to the effective length
  function automatic logic [kmrc_pkg::KMER_W-1:0] mirror_strand(
      input logic [kmrc_pkg::KMER_W-1:0] w,
      input logic [kmrc_pkg::LEN_W-1:0]  len);
    logic [kmrc_pkg::KMER_W-1:0] flip;
    logic [kmrc_pkg::KMER_W-1:0] acc;
    int                          syms;
    flip = ~w;
    syms = (len == '0) ? 1 :
           ((len > kmrc_pkg::LEN_MAX) ? int'(kmrc_pkg::SYMS) : int'(len));
    acc  = '0;
    for (int i = 0; i < syms; i++) begin
      acc[2*i +: 2] = flip[2*(syms-1-i) +: 2];
    end
    return acc;
  endfunction

  function automatic bit set_has(input logic [kmrc_pkg::KMER_W-1:0] v);
    for (int i = 0; i < int'(held_count); i++) begin
      if (held_kmers[i] == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    kmer_result_t                want;
    kmer_result_t                got;
    logic [kmrc_pkg::KMER_W-1:0] mate;
    kmrc_pkg::status_e           st;
    if (!rst_ni) begin
      held_count   = 0;
      kmer_len     = kmrc_pkg::LEN_RESET;
      fail_count_o = 0;
      due_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        kmer_len = cfg_data_i;
      end
      // outputs first, so a result never meets the prediction made this edge
      if (out_valid_i && out_ready_i) begin
        got = '{kmrc_pkg::status_e'(status_i), kmer_out_i, complement_out_i,
                unique_count_i, last_out_i};
        if (due_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("unexpected result: status %0d kmer %h comp %h count %0d last %0b",
                     got.status, got.kmer, got.mate, got.ucount, got.last);
          end
        end else begin
          want = due_results.pop_front();
          if (got.status !== want.status || got.kmer !== want.kmer ||
              got.mate !== want.mate || got.ucount !== want.ucount ||
              got.last !== want.last) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("mismatch: exp status %0d kmer %h comp %h count %0d last %0b",
                       want.status, want.kmer, want.mate, want.ucount, want.last);
              $display("          got status %0d kmer %h comp %h count %0d last %0b",
                       got.status, got.kmer, got.mate, got.ucount, got.last);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        mate = mirror_strand(kmer_i, kmer_len);
        if (set_has(mate)) begin
          st = kmrc_pkg::ST_SKIP;
        end else if (set_has(kmer_i)) begin
          st = kmrc_pkg::ST_DUP;
        end else if (held_count >= kmrc_pkg::CAPACITY) begin
          st = kmrc_pkg::ST_FULL;
        end else begin
          held_kmers[held_count] = kmer_i;
          held_count++;
          st = kmrc_pkg::ST_NEW;
        end
        due_results.push_back('{st, kmer_i, mate,
                                kmrc_pkg::UCOUNT_W'(held_count), last_item_i});
        if (last_item_i) begin
          held_count = 0;
        end
      end
    end
    pending_o = due_results.size();
  end

endmodule

// File: tb/tb_kmer_revcomp_dedup_set.sv
// ----------------------------------------------------------------------------
// tb_kmer_revcomp_dedup_set
// Drives the k-mer set with directed items under several k-mer lengths, one
// run that fills the table to capacity and beyond, then random runs built
// from fresh, short, repeated and complemented k-mers with random length
// changes in between. Both channels idle at random. The checker judges the
// results; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_kmer_revcomp_dedup_set;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [kmrc_pkg::LEN_W-1:0]    cfg_data_i  = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic [kmrc_pkg::KMER_W-1:0]   kmer_i      = '0;
  logic                          last_item_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [kmrc_pkg::STATUS_W-1:0] status_o;
  logic [kmrc_pkg::KMER_W-1:0]   kmer_out_o;
  logic [kmrc_pkg::KMER_W-1:0]   complement_out_o;
  logic [kmrc_pkg::UCOUNT_W-1:0] unique_count_o;
  logic                          last_out_o;

  logic                          calm = 1'b0;
  int unsigned                   pending;
  int unsigned                   fail_count;
  int unsigned                   cur_len = 31;
  logic [kmrc_pkg::KMER_W-1:0]   run_kmers [$];

  kmer_revcomp_dedup_set u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kmer_i           (kmer_i),
    .last_item_i      (last_item_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .kmer_out_o       (kmer_out_o),
    .complement_out_o (complement_out_o),
    .unique_count_o   (unique_count_o),
    .last_out_o       (last_out_o)
  );

  kmrc_checker u_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .kmer_i           (kmer_i),
    .last_item_i      (last_item_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_i         (status_o),
    .kmer_out_i       (kmer_out_o),
    .complement_out_i (complement_out_o),
    .unique_count_i   (unique_count_o),
    .last_out_i       (last_out_o),
    .pending_o        (pending),
    .fail_count_o     (fail_count)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 19);
  end

  // partner strand, used to provoke skips
  function automatic logic [kmrc_pkg::KMER_W-1:0] pair_strand(
      input logic [kmrc_pkg::KMER_W-1:0] w,
      input int unsigned                 k);
    logic [kmrc_pkg::KMER_W-1:0] r;
    r = '0;
    for (int i = 0; i < int'(k); i++) begin
      r[2*i +: 2] = 2'd3 - w[2*(int'(k)-1-i) +: 2];
    end
    return r;
  endfunction

  task automatic send_kmer(input logic [kmrc_pkg::KMER_W-1:0] word, input logic last);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kmer_i      <= word;
    last_item_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_kmer_len(input int unsigned len);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= kmrc_pkg::LEN_W'(len);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_len = (len == 0) ? 1 : ((len > kmrc_pkg::SYMS) ? kmrc_pkg::SYMS : len);
  endtask

  initial begin
    int unsigned                 sent;
    int                          run_len;
    int unsigned                 pick;
    logic [kmrc_pkg::KMER_W-1:0] word;
    logic [kmrc_pkg::KMER_W-1:0] mask;
    logic [kmrc_pkg::ADDR_W-1:0] spread;
    sent = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset length: new, skip on complement, duplicate, high bits ignored in the complement
    send_kmer('0, 1'b0);
    send_kmer('1, 1'b0);
    send_kmer('0, 1'b0);
    send_kmer(64'h8000_0000_0000_0000, 1'b0);
    send_kmer(64'hA5A5_5A5A_0F0F_F0F0, 1'b1);

    // zero length acts as one base
    set_kmer_len(0);
    send_kmer(64'd0, 1'b0);
    send_kmer(64'd3, 1'b0);
    send_kmer(64'd1, 1'b0);
    send_kmer(64'd2, 1'b1);

    // palindromes: stored first, skipped after
    set_kmer_len(2);
    send_kmer(64'd3, 1'b0);
    send_kmer(64'd3, 1'b0);
    send_kmer(64'd12, 1'b1);

    // length above the maximum saturates
    set_kmer_len(63);
    send_kmer('1, 1'b0);
    send_kmer('0, 1'b0);
    send_kmer(64'h0123_4567_89AB_CDEF, 1'b0);
    send_kmer(64'h5555_5555_5555_5555, 1'b1);

    // fill the table, spread over the slots, then push past capacity
    set_kmer_len(32);
    calm <= 1'b1;
    for (int i = 0; i < int'(kmrc_pkg::CAPACITY); i++) begin
      for (int b = 0; b < int'(kmrc_pkg::ADDR_W); b++) begin
        spread[b] = i[kmrc_pkg::ADDR_W-1-b];
      end
      send_kmer(kmrc_pkg::KMER_W'(spread), 1'b0);
    end
    send_kmer(kmrc_pkg::KMER_W'(kmrc_pkg::CAPACITY), 1'b0);
    send_kmer(64'hDEAD_BEEF_0000_0000, 1'b0);
    send_kmer('0, 1'b0);
    send_kmer(pair_strand(64'd5, kmrc_pkg::SYMS), 1'b0);
    send_kmer(64'h7777, 1'b1);
    calm <= 1'b0;

    while (sent < 1500) begin
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(6))
          0:       set_kmer_len(0);
          1:       set_kmer_len(1);
          2:       set_kmer_len(2);
          3:       set_kmer_len(32);
          4:       set_kmer_len(63);
          5:       set_kmer_len($urandom_range(62, 33));
          default: set_kmer_len($urandom_range(31, 3));
        endcase
      end
      run_kmers.delete();
      run_len = ($urandom_range(9) == 0) ? $urandom_range(120, 60) : $urandom_range(24, 1);
      mask = (cur_len >= kmrc_pkg::SYMS) ? '1 : ((64'd1 << (2 * cur_len)) - 64'd1);
      for (int j = 0; j < run_len; j++) begin
        pick = $urandom_range(99);
        if (pick < 30 || run_kmers.size() == 0) begin
          word = {$urandom, $urandom};
        end else if (pick < 50) begin
          word = {$urandom, $urandom} & mask;
        end else if (pick < 72) begin
          word = run_kmers[$urandom_range(run_kmers.size() - 1)];
        end else begin
          word = pair_strand(run_kmers[$urandom_range(run_kmers.size() - 1)], cur_len);
        end
        send_kmer(word, j == run_len - 1);
        run_kmers.push_back(word);
        sent++;
      end
    end

    drain();
    repeat (32) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(64'd2_000_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
hdl/kmrc_pkg.sv
hdl/kmer_revcomp_dedup_set.sv
tb/kmrc_checker.sv
tb/tb_kmer_revcomp_dedup_set.sv
